>>> hw/rtl/pft_pkg.sv
// pft_pkg: shared types and constants for the page frame translator
// used by the interfaces, controller, datapath and top level; no dependencies

package pft_pkg;

   // fixed field widths of the request and response payloads
   localparam int LOG_ADDR_W = 32;
   localparam int PHYS_ADDR_W = 20;
   localparam int FRAME_IDX_W = 8;

   // parameter defaults
   localparam int DEF_OFFSET_BITS = 12;
   localparam int DEF_ADDRESS_BITS = 32;
   localparam int DEF_NUM_FRAMES = 256;

   // response status codes
   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_NO_FRAME = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DELIVER
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request, restart scan
      logic issue;      // read next table entry
      logic set_hit;    // result: page found at checked entry
      logic set_alloc;  // result: assign next free frame
      logic set_full;   // result: no frame left
      logic deliver;    // move result into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_more;   // entries left to read
      logic match;       // entry read last cycle holds the page
      logic table_full;  // every frame in use
      logic out_free;    // output register can take a result
   } status_type;

endpackage

>>> hw/rtl/pft_if.sv
// pft_if: request and response channel interfaces of the page frame translator
// depends on pft_pkg for payload widths

interface pft_req_if;
   logic                         valid;
   logic                         ready;
   logic [pft_pkg::LOG_ADDR_W-1:0] logical_address;

   modport source (output valid, output logical_address, input ready);
   modport sink (input valid, input logical_address, output ready);
endinterface

interface pft_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [pft_pkg::PHYS_ADDR_W-1:0] physical_address;
   logic [pft_pkg::FRAME_IDX_W-1:0] frame_index;
   logic                           was_present;
   logic                           status;

   modport source (output valid, output physical_address, output frame_index,
                   output was_present, output status, input ready);
   modport sink (input valid, input physical_address, input frame_index,
                 input was_present, input status, output ready);
endinterface

>>> hw/rtl/pft_ram.sv
// pft_ram: generic single write port, single read port ram with registered read
// no dependencies

module pft_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 256
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/pft_ctrl.sv
// pft_ctrl: controller state machine of the page frame translator
// depends on pft_pkg for state, command and status types

module pft_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pft_pkg::status_type status,
   output pft_pkg::cmd_type    cmd
);

   pft_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pft_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         pft_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = pft_pkg::ST_SEARCH;
            end
         end
         pft_pkg::ST_SEARCH: begin
            if (status.match) begin
               cmd.set_hit = 1'b1;
               state_in = pft_pkg::ST_DELIVER;
            end else if (status.scan_more) begin
               cmd.issue = 1'b1;
            end else if (status.table_full) begin
               cmd.set_full = 1'b1;
               state_in = pft_pkg::ST_DELIVER;
            end else begin
               cmd.set_alloc = 1'b1;
               state_in = pft_pkg::ST_DELIVER;
            end
         end
         pft_pkg::ST_DELIVER: begin
            if (status.out_free) begin
               cmd.deliver = 1'b1;
               state_in = pft_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pft_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> hw/rtl/pft_datapath.sv
// pft_datapath: frame table, scan counter, result and output registers
// depends on pft_pkg and pft_ram

module pft_datapath #(
   parameter int OFFSET_BITS = pft_pkg::DEF_OFFSET_BITS,
   parameter int ADDRESS_BITS = pft_pkg::DEF_ADDRESS_BITS,
   parameter int NUM_FRAMES = pft_pkg::DEF_NUM_FRAMES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [pft_pkg::LOG_ADDR_W-1:0]    logical_address,
   input  pft_pkg::cmd_type                  cmd,
   output pft_pkg::status_type               status,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pft_pkg::PHYS_ADDR_W-1:0]   physical_address,
   output logic [pft_pkg::FRAME_IDX_W-1:0]   frame_index,
   output logic                              was_present,
   output logic                              rsp_status
);

   localparam int ADDR_USED = (ADDRESS_BITS < pft_pkg::LOG_ADDR_W) ?
                              ADDRESS_BITS : pft_pkg::LOG_ADDR_W;
   localparam int PAGE_BITS = (ADDR_USED > OFFSET_BITS) ? ADDR_USED - OFFSET_BITS : 1;
   localparam int FRAME_BITS = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int CNT_BITS = $clog2(NUM_FRAMES + 1);
   localparam int PA_W = FRAME_BITS + OFFSET_BITS;
   localparam int PA_EXT = (PA_W > pft_pkg::PHYS_ADDR_W) ? PA_W : pft_pkg::PHYS_ADDR_W;
   localparam int FI_EXT = (FRAME_BITS > pft_pkg::FRAME_IDX_W) ?
                           FRAME_BITS : pft_pkg::FRAME_IDX_W;
   localparam logic [pft_pkg::LOG_ADDR_W-1:0] ADDR_MASK =
      (ADDR_USED >= pft_pkg::LOG_ADDR_W) ? '1 :
      ((pft_pkg::LOG_ADDR_W'(1) << ADDR_USED) - pft_pkg::LOG_ADDR_W'(1));
   localparam logic [CNT_BITS-1:0] FRAMES_MAX = CNT_BITS'(NUM_FRAMES);

   logic [pft_pkg::LOG_ADDR_W-1:0] addr_masked;
   logic [pft_pkg::LOG_ADDR_W-1:0] page_wide;

   logic [PAGE_BITS-1:0]   page_ff;
   logic [OFFSET_BITS-1:0] offset_ff;
   logic [CNT_BITS-1:0]    used_ff, used_in;
   logic [CNT_BITS-1:0]    scan_ff, scan_in;
   logic                   chk_valid_ff, chk_valid_in;
   logic [FRAME_BITS-1:0]  chk_idx_ff;
   logic [FRAME_BITS-1:0]  res_frame_ff;
   logic                   res_hit_ff;
   logic                   res_full_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [pft_pkg::PHYS_ADDR_W-1:0] pa_ff;
   logic [pft_pkg::FRAME_IDX_W-1:0] fi_ff;
   logic                   hit_ff;
   logic                   stat_ff;
   logic [PAGE_BITS-1:0]   rd_data;
   logic [PA_EXT-1:0]      pa_ext;
   logic [FI_EXT-1:0]      fi_ext;

   assign addr_masked = logical_address & ADDR_MASK;
   assign page_wide = addr_masked >> OFFSET_BITS;

   pft_ram #(
      .WIDTH (PAGE_BITS),
      .DEPTH (NUM_FRAMES)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.set_alloc),
      .wr_addr (used_ff[FRAME_BITS-1:0]),
      .wr_data (page_ff),
      .rd_en   (cmd.issue),
      .rd_addr (scan_ff[FRAME_BITS-1:0]),
      .rd_data (rd_data)
   );

   assign status.scan_more = scan_ff < used_ff;
   assign status.match = chk_valid_ff && (rd_data == page_ff);
   assign status.table_full = used_ff == FRAMES_MAX;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      used_in = used_ff;
      if (cmd.set_alloc) begin
         used_in = used_ff + CNT_BITS'(1);
      end
      scan_in = scan_ff;
      if (cmd.load) begin
         scan_in = '0;
      end else if (cmd.issue) begin
         scan_in = scan_ff + CNT_BITS'(1);
      end
      chk_valid_in = cmd.issue;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.deliver) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         scan_ff <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
         scan_ff <= scan_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output formatting, widths folded to the response fields
   assign pa_ext = PA_EXT'({res_frame_ff, offset_ff});
   assign fi_ext = FI_EXT'(res_frame_ff);

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         page_ff <= page_wide[PAGE_BITS-1:0];
         offset_ff <= logical_address[OFFSET_BITS-1:0];
      end
      if (cmd.issue) begin
         chk_idx_ff <= scan_ff[FRAME_BITS-1:0];
      end
      if (cmd.set_hit) begin
         res_frame_ff <= chk_idx_ff;
         res_hit_ff <= 1'b1;
         res_full_ff <= pft_pkg::STATUS_OK;
      end else if (cmd.set_alloc) begin
         res_frame_ff <= used_ff[FRAME_BITS-1:0];
         res_hit_ff <= 1'b0;
         res_full_ff <= pft_pkg::STATUS_OK;
      end else if (cmd.set_full) begin
         res_frame_ff <= '0;
         res_hit_ff <= 1'b0;
         res_full_ff <= pft_pkg::STATUS_NO_FRAME;
      end
      if (cmd.deliver) begin
         pa_ff <= res_full_ff ? '0 : pa_ext[pft_pkg::PHYS_ADDR_W-1:0];
         fi_ff <= fi_ext[pft_pkg::FRAME_IDX_W-1:0];
         hit_ff <= res_hit_ff;
         stat_ff <= res_full_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign physical_address = pa_ff;
   assign frame_index = fi_ff;
   assign was_present = hit_ff;
   assign rsp_status = stat_ff;

   // frame count never passes the table depth
   assert property (@(posedge clock) disable iff (reset) used_ff <= FRAMES_MAX)
      else $error("frame count above table depth");

   // allocation only with a free frame
   assert property (@(posedge clock) disable iff (reset)
      cmd.set_alloc |-> (used_ff < FRAMES_MAX))
      else $error("allocation with no free frame");

   // a hit comes from an entry below the frame count
   assert property (@(posedge clock) disable iff (reset)
      cmd.set_hit |-> (CNT_BITS'(chk_idx_ff) < used_ff))
      else $error("hit on an unassigned frame");

   // out of frames leaves the count untouched
   assert property (@(posedge clock) disable iff (reset)
      cmd.set_full |=> $stable(used_ff))
      else $error("frame count changed on out of frames");

   // a result never overwrites one not yet taken
   assert property (@(posedge clock) disable iff (reset)
      cmd.deliver |-> (!rsp_valid_ff || rsp_ready))
      else $error("output register overrun");

endmodule

>>> hw/rtl/page_frame_translator.sv
// page_frame_translator: top level, paged address translation with frame allocation
// depends on pft_pkg, pft_if, pft_ctrl, pft_datapath (and pft_ram below it)
//
// usage
// - req_chan carries one logical address per request (valid/ready, accepted
//   when both are high); the low OFFSET_BITS bits are the page offset, the
//   bits up to ADDRESS_BITS the page number
// - rsp_chan returns exactly one response per request, in order: physical
//   address, frame index, a was_present flag and a status
// - the frame table lives in a ram with registered read and is scanned one
//   entry per cycle from frame 0 up to the current frame count
// - after a request is accepted the table is scanned until the page is found or
//   the frame count is reached, then the result is picked and loaded into the
//   output register; the next request is taken in the cycle after the response
//   is loaded, so requests are searched one at a time, each after the last result
// - a miss assigns the next free frame; with every frame in use the response
//   has status 1, all other fields zero, and no state changes
// - reset clears the frame count and the handshake state; the table itself
//   is not cleared, entries are only read after being written
// - the response sits in an output register; if the receiver stalls, a new
//   request is still accepted and searched, and its result waits in the
//   datapath until the output register frees up

module page_frame_translator #(
   parameter int OFFSET_BITS = pft_pkg::DEF_OFFSET_BITS,
   parameter int ADDRESS_BITS = pft_pkg::DEF_ADDRESS_BITS,
   parameter int NUM_FRAMES = pft_pkg::DEF_NUM_FRAMES
) (
   input  logic          clock,
   input  logic          reset,
   pft_req_if.sink       req_chan,
   pft_rsp_if.source     rsp_chan
);

   // command and status between controller and datapath
   pft_pkg::cmd_type    cmd;
   pft_pkg::status_type status;

   // state machine: accept, scan, pick result, hand to output register
   pft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // frame table, scan counter, frame count, output register
   pft_datapath #(
      .OFFSET_BITS  (OFFSET_BITS),
      .ADDRESS_BITS (ADDRESS_BITS),
      .NUM_FRAMES   (NUM_FRAMES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .logical_address  (req_chan.logical_address),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .physical_address (rsp_chan.physical_address),
      .frame_index      (rsp_chan.frame_index),
      .was_present      (rsp_chan.was_present),
      .rsp_status       (rsp_chan.status)
   );

endmodule

>>> tb/tb_top.sv
// tb_top: self-checking bench for page_frame_translator (page lookup and frame allocation)
// depends on pft_pkg, pft_if and the page_frame_translator rtl; predicts every response
// from its own copy of the frame table

module tb_top;

   // block configuration, kept at the package defaults
   localparam int OFFSET_BITS = pft_pkg::DEF_OFFSET_BITS;
   localparam int ADDRESS_BITS = pft_pkg::DEF_ADDRESS_BITS;
   localparam int NUM_FRAMES = pft_pkg::DEF_NUM_FRAMES;
   localparam int PAGE_W = ADDRESS_BITS - OFFSET_BITS;

   // a full table scan plus output cycles, used for the final drain
   localparam int DRAIN_CYCLES = NUM_FRAMES + 40;
   // long receiver stall, several full scans, so the block backs up into its input
   localparam int RSP_HOLD_CYCLES = 2000;
   // cycles without any handshake before the run is declared hung
   localparam int STALL_LIMIT = 10000;

   typedef struct packed {
      logic [pft_pkg::PHYS_ADDR_W-1:0] physical_address;
      logic [pft_pkg::FRAME_IDX_W-1:0] frame_index;
      logic                            was_present;
      logic                            status;
   } translation_type;

   logic clock;
   logic reset = 1'b1;

   pft_req_if req_chan ();
   pft_rsp_if rsp_chan ();

   page_frame_translator #(
      .OFFSET_BITS (OFFSET_BITS),
      .ADDRESS_BITS(ADDRESS_BITS),
      .NUM_FRAMES  (NUM_FRAMES)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // ---------------------------------------------------------------------
   // shadow frame table: page held by each frame plus the frame count
   // ---------------------------------------------------------------------
   logic [PAGE_W-1:0] frame_pages [NUM_FRAMES];
   int                frames_in_use = 0;

   // expected responses, oldest first
   translation_type   pending_translations [$];

   int  mismatch_count = 0;
   bit  steady_flow = 1'b0;     // both sides run without idle gaps
   bit  rsp_hold_pending = 1'b0; // receiver takes one long stall at its next response

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // look the page up in the shadow table and allocate on a miss, exactly as
   // the block does: first match in frame order, next free frame otherwise
   function automatic translation_type translate_and_allocate(
      input logic [pft_pkg::LOG_ADDR_W-1:0] addr);
      logic [PAGE_W-1:0]      page;
      logic [OFFSET_BITS-1:0] offset;
      translation_type        result;
      int                     hit_frame;
      int                     frame;
      int                     phys_full;
      int                     k;
      page = addr[ADDRESS_BITS-1:OFFSET_BITS];
      offset = addr[OFFSET_BITS-1:0];
      result = '0;
      hit_frame = -1;
      for (k = 0; k < frames_in_use; k++) begin
         if (hit_frame < 0 && frame_pages[k] == page) begin
            hit_frame = k;
         end
      end
      if (hit_frame >= 0) begin
         frame = hit_frame;
         result.was_present = 1'b1;
      end else if (frames_in_use == NUM_FRAMES) begin
         // out of frames: everything zero, nothing assigned
         result.status = pft_pkg::STATUS_NO_FRAME;
         return result;
      end else begin
         frame = frames_in_use;
         frame_pages[frames_in_use] = page;
         frames_in_use++;
      end
      phys_full = (frame << OFFSET_BITS) + int'(offset);
      result.physical_address = phys_full[pft_pkg::PHYS_ADDR_W-1:0];
      result.frame_index = frame[pft_pkg::FRAME_IDX_W-1:0];
      result.status = pft_pkg::STATUS_OK;
      return result;
   endfunction

   // random offset on a page that already holds a frame
   function automatic logic [pft_pkg::LOG_ADDR_W-1:0] resident_page_address();
      int idx;
      logic [pft_pkg::LOG_ADDR_W-1:0] addr;
      idx = $urandom_range(0, frames_in_use - 1);
      addr = $urandom;
      addr[ADDRESS_BITS-1:OFFSET_BITS] = frame_pages[idx];
      return addr;
   endfunction

   // ---------------------------------------------------------------------
   // request side: one address per call, valid stays up when no gap is drawn
   // ---------------------------------------------------------------------
   task automatic send_address(input logic [pft_pkg::LOG_ADDR_W-1:0] addr);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.logical_address <= addr;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      // accepted at this edge: predict now, in acceptance order
      pending_translations.push_back(translate_and_allocate(addr));
   endtask

   // ---------------------------------------------------------------------
   // response side: random ready gaps, one long stall on request, checks
   // each response against the oldest expectation
   // ---------------------------------------------------------------------
   task automatic compare_translation(input translation_type got);
      translation_type want;
      if (pending_translations.size() == 0) begin
         $error("response with no request outstanding: frame_index %0d status %0d",
                got.frame_index, got.status);
         mismatch_count++;
         return;
      end
      want = pending_translations.pop_front();
      if (got.physical_address !== want.physical_address) begin
         $error("physical_address mismatch: expected %h, actual %h",
                want.physical_address, got.physical_address);
         mismatch_count++;
      end
      if (got.frame_index !== want.frame_index) begin
         $error("frame_index mismatch: expected %0d, actual %0d",
                want.frame_index, got.frame_index);
         mismatch_count++;
      end
      if (got.was_present !== want.was_present) begin
         $error("was_present mismatch: expected %b, actual %b",
                want.was_present, got.was_present);
         mismatch_count++;
      end
      if (got.status !== want.status) begin
         $error("status mismatch: expected %b, actual %b", want.status, got.status);
         mismatch_count++;
      end
   endtask

   initial begin : response_sink
      int              gap;
      translation_type got;
      rsp_chan.ready <= 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (rsp_hold_pending) begin
            // long stall: the datapath fills up behind the output register
            gap = RSP_HOLD_CYCLES;
            rsp_hold_pending = 1'b0;
         end else begin
            gap = steady_flow ? 0 : $urandom_range(0, 16);
         end
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         got.physical_address = rsp_chan.physical_address;
         got.frame_index = rsp_chan.frame_index;
         got.was_present = rsp_chan.was_present;
         got.status = rsp_chan.status;
         compare_translation(got);
      end
   end

   // hang detection: any handshake on either channel restarts the count
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // corner addresses: all-zero and all-one pages and offsets, alternating
   // bit patterns, single-bit pages, most of them revisited to check the hit path
   task test_corner_addresses();
      logic [pft_pkg::LOG_ADDR_W-1:0] corner_addrs [0:17] = '{
         32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0FFF, 32'hFFFF_F000,
         32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_A555, 32'h5555_5AAA,
         32'h0000_1000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_1001,
         32'h8000_0800, 32'h0000_0001, 32'h1234_5678, 32'h1234_5ABC,
         32'hFFFF_FFFE, 32'h0001_0000};
      int i;
      for (i = 0; i < 18; i++) begin
         send_address(corner_addrs[i]);
      end
   endtask

   // hits on resident pages with fresh pages mixed in at miss_pct percent, so the table
   // grows gradually and searches get longer over time
   task automatic test_mixed_lookups(input int count, input int miss_pct);
      int i;
      for (i = 0; i < count; i++) begin
         // switch between idle gaps and back-to-back stretches now and then
         if (i % 40 == 0) steady_flow = ($urandom_range(0, 3) == 0);
         if (frames_in_use > 0 && $urandom_range(0, 99) >= miss_pct) begin
            send_address(resident_page_address());
         end else begin
            send_address($urandom);
         end
      end
      steady_flow = 1'b0;
   endtask

   // receiver stalls for a long stretch while requests keep coming back to
   // back, so the block holds one result per stage and then blocks its input
   task automatic test_backpressure();
      int i;
      steady_flow = 1'b1;
      rsp_hold_pending = 1'b1;
      for (i = 0; i < 12; i++) begin
         if (i % 2 == 0 && frames_in_use > 0) begin
            send_address(resident_page_address());
         end else begin
            send_address($urandom);
         end
      end
      steady_flow = 1'b0;
   endtask

   // fresh pages until every frame is assigned
   task automatic test_fill_table();
      while (frames_in_use < NUM_FRAMES) begin
         send_address($urandom);
      end
   endtask

   // table full: misses must report out of frames and leave the table alone,
   // which the hits that follow confirm
   task automatic test_out_of_frames(input int count);
      test_mixed_lookups(count, 50);
   endtask

   initial begin : stimulus
      req_chan.valid <= 1'b0;
      req_chan.logical_address <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_addresses();
      test_mixed_lookups(500, 30);
      test_backpressure();
      test_fill_table();
      test_out_of_frames(700);

      req_chan.valid <= 1'b0;
      while (pending_translations.size() != 0) @(posedge clock);
      // let any stray response show up
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending_translations.size() != 0) begin
         $error("%0d responses never arrived", pending_translations.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
